### src/att_pkg.sv
// Shared types and constants for the affine transform accumulator.
// Op codes, inter-module control structs and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

    // Op codes of an input transfer
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_ROTATE    = 2'd1;
    localparam logic [1:0] OP_SCALE     = 2'd2;
    localparam logic [1:0] OP_LOAD      = 2'd3;

    // Fixed CORDIC gain correction in Q2.30, and the longest usable table
    localparam int unsigned                CORDIC_MAX_STEPS = 24;
    localparam logic signed [33:0]         CORDIC_GAIN_Q30  = 34'sd652032874;

    typedef logic [1:0] t_op;

    // Control travelling alongside one operand pair into the MAC
    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic [3:0] ent;
    } t_mac_ctl;

    // Result of one sine/cosine evaluation
    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } t_sc_res;

    // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/att_mat_mem.sv
// Matrix store: 16 x 32-bit synchronous memory, one write and one read port.
// Per-entry valid bits make unwritten entries read as identity. Uses att_pkg.
`timescale 1ns / 1ps
`default_nettype none

module att_mat_mem #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_we,
    input  wire logic [3:0]         i_waddr,
    input  wire logic signed [31:0] i_wdata,
    input  wire logic [3:0]         i_raddr,
    output logic signed [31:0]      o_rdata
);
    import att_pkg::*;

    logic signed [31:0] r_mem [16];
    logic [15:0]        r_vld;
    logic signed [31:0] r_rdata;
    logic               r_rvld;
    logic [3:0]         r_raddr;
    logic signed [31:0] w_ident;

    // Track which entries have been written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
        r_rvld  <= r_vld[i_raddr];
        r_raddr <= i_raddr;
    end

    // Unwritten entries hold the identity value
    assign w_ident = (r_raddr[1:0] == r_raddr[3:2]) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
    assign o_rdata = r_rvld ? r_rdata : w_ident;

endmodule

`default_nettype wire

### src/att_sincos.sv
// Sine and cosine of a fixed-point angle in degrees.
// Radix-256 division by 360 through a reciprocal multiply, then an iterative CORDIC.
// Uses att_pkg.
`timescale 1ns / 1ps
`default_nettype none

module att_sincos #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_deg,
    output att_pkg::t_sc_res        o_res
);
    import att_pkg::*;

    localparam int DW      = 64 - FRAC_BITS;
    localparam int ND      = (DW + 7) / 8;
    localparam int NW      = ND * 8;
    localparam int CW      = $clog2(ND + 1);
    localparam int N_ITERS = (CORDIC_ITERS < CORDIC_MAX_STEPS) ? CORDIC_ITERS
                                                               : CORDIC_MAX_STEPS;
    localparam int SH      = 30 - FRAC_BITS;
    // ceil(2^26 / 360): exact quotient for every digit step below 360 * 256
    localparam logic [17:0] RECIP_360 = 18'd186414;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_ROT  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]         r_state;
    logic [NW-1:0]      r_num;
    logic [8:0]         r_rem;
    logic [31:0]        r_quo;
    logic               r_neg;
    logic [CW-1:0]      r_cnt;
    logic               r_ph;
    logic [7:0]         r_qd;
    logic signed [33:0] r_cx;
    logic signed [33:0] r_cy;
    logic signed [32:0] r_z;
    logic [1:0]         r_quad;
    logic [4:0]         r_i;
    logic               r_done;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;

    logic [31:0]        w_mag;
    logic [16:0]        w_dig;
    logic [33:0]        w_prod;
    logic [7:0]         w_qd;
    logic [31:0]        w_theta;
    logic [31:0]        w_phi;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [32:0] w_atan;
    logic signed [33:0] w_qc;
    logic signed [33:0] w_qs;
    logic signed [33:0] w_rc;
    logic signed [33:0] w_rs;

    // Angle magnitude, digit quotient, turn fraction and CORDIC deltas
    always_comb begin
        w_mag   = i_deg[31] ? (~i_deg + 32'd1) : i_deg;
        w_dig   = {r_rem, r_num[NW-1 -: 8]};
        w_prod  = 34'(w_dig) * 34'(RECIP_360);
        w_qd    = w_prod[33:26];
        w_theta = r_neg ? (32'd0 - (r_quo + {31'd0, (r_rem != 9'd0)})) : r_quo;
        w_phi   = w_theta + 32'h2000_0000;
        w_dx    = r_cy >>> r_i;
        w_dy    = r_cx >>> r_i;
        w_atan  = $signed({1'b0, atan_turn(r_i)});
    end

    // Rotate by the quadrant, then round Q2.30 down to the output format
    always_comb begin
        case (r_quad)
            2'd1:    begin w_qc = -r_cy; w_qs = r_cx;  end
            2'd2:    begin w_qc = -r_cx; w_qs = -r_cy; end
            2'd3:    begin w_qc = r_cy;  w_qs = -r_cx; end
            default: begin w_qc = r_cx;  w_qs = r_cy;  end
        endcase
        w_rc = (w_qc + (34'sd1 <<< (SH - 1))) >>> SH;
        w_rs = (w_qs + (34'sd1 <<< (SH - 1))) >>> SH;
    end

    // Sequence: divide, prepare, iterate, finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_ph && (r_cnt == CW'(ND - 1))) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: r_state <= S_ROT;
                S_ROT: begin
                    if (r_i == 5'(N_ITERS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_num <= NW'({w_mag, (32 - FRAC_BITS)'(0)});
                r_neg <= i_deg[31];
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
                r_ph  <= 1'b0;
            end
            S_DIV: begin
                // Quotient digit first, then remainder and shift on the next cycle
                if (!r_ph) begin
                    r_qd <= w_qd;
                    r_ph <= 1'b1;
                end else begin
                    r_rem <= 9'(w_dig - 17'(r_qd) * 17'd360);
                    r_quo <= {r_quo[23:0], r_qd};
                    r_num <= r_num << 8;
                    r_cnt <= r_cnt + CW'(1);
                    r_ph  <= 1'b0;
                end
            end
            S_PREP: begin
                r_quad <= w_phi[31:30];
                r_z    <= $signed({3'b000, w_phi[29:0]}) - 33'sd536870912;
                r_cx   <= CORDIC_GAIN_Q30;
                r_cy   <= '0;
                r_i    <= '0;
            end
            S_ROT: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_z  <= r_z - w_atan;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_z  <= r_z + w_atan;
                end
                r_i <= r_i + 5'd1;
            end
            S_FIN: begin
                r_cos <= 32'(w_rc);
                r_sin <= 32'(w_rs);
            end
            default: begin
            end
        endcase
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_cos;
    assign o_res.sin_v = r_sin;

endmodule

`default_nettype wire

### src/att_mac.sv
// Multiply-accumulate unit for one matrix product entry.
// Registered 32x32 multiply, 66-bit accumulate, round and saturate. Uses att_pkg.
`timescale 1ns / 1ps
`default_nettype none

module att_mac #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  att_pkg::t_mac_ctl       i_ctl,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic                    o_wr_vld,
    output logic [3:0]              o_wr_ent,
    output logic signed [31:0]      o_wr_val
);
    import att_pkg::*;

    localparam logic signed [65:0] MAX_V = 66'sd2147483647;
    localparam logic signed [65:0] MIN_V = -66'sd2147483648;

    t_mac_ctl           r_c1;
    logic signed [63:0] r_p;
    logic               r_c2_vld;
    logic [3:0]         r_c2_ent;
    logic signed [65:0] r_acc;
    logic               r_out_vld;
    logic [3:0]         r_out_ent;
    logic signed [31:0] r_out_val;

    logic signed [65:0] w_rnd;
    logic signed [65:0] w_shr;
    logic signed [31:0] w_sat;

    // Round to nearest, ties up, then clamp to 32 bits
    always_comb begin
        w_rnd = r_acc + (66'sd1 <<< (FRAC_BITS - 1));
        w_shr = w_rnd >>> FRAC_BITS;
        if (w_shr > MAX_V) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_shr < MIN_V) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = 32'(w_shr);
        end
    end

    // Control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.vld  <= 1'b0;
            r_c2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_c1.vld  <= i_ctl.vld;
            r_c2_vld  <= r_c1.vld & r_c1.last;
            r_out_vld <= r_c2_vld;
        end
    end

    // Multiply, accumulate, finish
    always_ff @(posedge i_clk) begin
        r_c1.first <= i_ctl.first;
        r_c1.last  <= i_ctl.last;
        r_c1.ent   <= i_ctl.ent;
        r_p        <= i_a * i_b;
        if (r_c1.vld) begin
            r_acc <= r_c1.first ? 66'(r_p) : r_acc + 66'(r_p);
        end
        r_c2_ent  <= r_c1.ent;
        r_out_ent <= r_c2_ent;
        r_out_val <= w_sat;
    end

    assign o_wr_vld = r_out_vld;
    assign o_wr_ent = r_out_ent;
    assign o_wr_val = r_out_val;

endmodule

`default_nettype wire

### src/affine_transform_accumulator.sv
// Affine transform accumulator: 4x4 Q16.16 matrix held in memory, updated by ops.
// Each op ends with all sixteen entries emitted; translate and scale run a 64-step MAC
// pass and a copy-back of the product, rotate runs a sine/cosine evaluation, a MAC pass
// and a copy-back per axis, and load goes straight to emitting the entries.
// One item at a time; input is stalled until the sixteenth entry is taken.
// Synchronous reset returns the matrix to identity and the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module affine_transform_accumulator #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_y,
    input  wire logic signed [31:0] i_z,
    input  wire logic [3:0]         i_entry_index,
    input  wire logic signed [31:0] i_entry_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_out_index,
    output logic signed [31:0]      o_out_value,
    output logic                    o_last
);
    import att_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SC_GO     = 4'd1;
    localparam logic [3:0] S_SC_WAIT   = 4'd2;
    localparam logic [3:0] S_MUL       = 4'd3;
    localparam logic [3:0] S_DRAIN     = 4'd4;
    localparam logic [3:0] S_COPY      = 4'd5;
    localparam logic [3:0] S_CP_FIN    = 4'd6;
    localparam logic [3:0] S_EMIT_RD   = 4'd7;
    localparam logic [3:0] S_EMIT_LD   = 4'd8;
    localparam logic [3:0] S_EMIT_WAIT = 4'd9;

    logic [3:0]         r_state;
    t_op                r_op;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic [1:0]         r_axis;
    logic [5:0]         r_step;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;
    t_mac_ctl           r_m_ctl;
    logic [1:0]         r_m_k;
    logic signed [31:0] r_scr [16];
    logic signed [31:0] r_scr_rd;
    logic               r_cp_vld;
    logic [3:0]         r_cp_addr;
    logic [3:0]         r_ent;
    logic               r_ovld;
    logic [3:0]         r_oidx;
    logic signed [31:0] r_oval;
    logic               r_olast;

    logic               w_accept;
    logic               w_we;
    logic [3:0]         w_waddr;
    logic signed [31:0] w_wdata;
    logic [3:0]         w_raddr;
    logic signed [31:0] w_rdata;
    logic signed [31:0] w_deg;
    t_sc_res            w_sc;
    logic signed [31:0] w_b;
    logic signed [31:0] w_one;
    logic               w_mac_vld;
    logic [3:0]         w_mac_ent;
    logic signed [31:0] w_mac_val;

    assign w_one    = 32'sd1 <<< FRAC_BITS;
    assign w_accept = i_valid & ~o_stall;
    assign o_stall  = (r_state != S_IDLE);

    // Matrix port selection: load or copy-back writes, MAC or emit reads
    always_comb begin
        w_we    = r_cp_vld | (w_accept & (i_op == OP_LOAD));
        w_waddr = r_cp_vld ? r_cp_addr : i_entry_index;
        w_wdata = r_cp_vld ? r_scr_rd : i_entry_value;
        w_raddr = (r_state == S_MUL) ? {r_step[5:4], r_step[1:0]} : r_ent;
        case (r_axis)
            2'd0:    w_deg = r_x;
            2'd1:    w_deg = r_y;
            default: w_deg = r_z;
        endcase
    end

    // Right-hand operand entry at row k, column c
    always_comb begin
        w_b = ((r_m_k == r_m_ctl.ent[1:0]) && (r_op != OP_SCALE)) ? w_one : 32'sd0;
        case (r_op)
            OP_TRANSLATE: begin
                case ({r_m_k, r_m_ctl.ent[1:0]})
                    4'b0011: w_b = r_x;
                    4'b0111: w_b = r_y;
                    4'b1011: w_b = r_z;
                    default: begin
                    end
                endcase
            end
            OP_SCALE: begin
                case ({r_m_k, r_m_ctl.ent[1:0]})
                    4'b0000: w_b = r_x;
                    4'b0101: w_b = r_y;
                    4'b1010: w_b = r_z;
                    4'b1111: w_b = w_one;
                    default: begin
                    end
                endcase
            end
            default: begin
                case ({r_axis, r_m_k, r_m_ctl.ent[1:0]})
                    6'b00_0101: w_b = r_cos;
                    6'b00_0110: w_b = -r_sin;
                    6'b00_1001: w_b = r_sin;
                    6'b00_1010: w_b = r_cos;
                    6'b01_0000: w_b = r_cos;
                    6'b01_0010: w_b = r_sin;
                    6'b01_1000: w_b = -r_sin;
                    6'b01_1010: w_b = r_cos;
                    6'b10_0000: w_b = r_cos;
                    6'b10_0001: w_b = -r_sin;
                    6'b10_0100: w_b = r_sin;
                    6'b10_0101: w_b = r_cos;
                    default: begin
                    end
                endcase
            end
        endcase
    end

    att_mat_mem #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    att_sincos #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SC_GO),
        .i_deg   (w_deg),
        .o_res   (w_sc)
    );

    att_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_m_ctl),
        .i_a      (w_rdata),
        .i_b      (w_b),
        .o_wr_vld (w_mac_vld),
        .o_wr_ent (w_mac_ent),
        .o_wr_val (w_mac_val)
    );

    // Product scratch memory: MAC writes, copy-back reads
    always_ff @(posedge i_clk) begin
        if (w_mac_vld) begin
            r_scr[w_mac_ent] <= w_mac_val;
        end
        r_scr_rd  <= r_scr[r_step[3:0]];
        r_cp_addr <= r_step[3:0];
    end

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m_ctl.vld <= 1'b0;
            r_cp_vld    <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_m_ctl.vld <= (r_state == S_MUL);
            r_cp_vld    <= (r_state == S_COPY);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_step <= '0;
                        r_ent  <= '0;
                        r_axis <= '0;
                        case (i_op)
                            OP_LOAD:   r_state <= S_EMIT_RD;
                            OP_ROTATE: r_state <= S_SC_GO;
                            default:   r_state <= S_MUL;
                        endcase
                    end
                end
                S_SC_GO: r_state <= S_SC_WAIT;
                S_SC_WAIT: begin
                    if (w_sc.done) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd63) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_mac_vld && (w_mac_ent == 4'd15)) begin
                        r_step  <= '0;
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    r_step <= r_step + 6'd1;
                    if (r_step[3:0] == 4'd15) begin
                        r_state <= S_CP_FIN;
                    end
                end
                S_CP_FIN: begin
                    if ((r_op == OP_ROTATE) && (r_axis != 2'd2)) begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_SC_GO;
                    end else begin
                        r_ent   <= '0;
                        r_state <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: r_state <= S_EMIT_LD;
                S_EMIT_LD: begin
                    r_ovld  <= 1'b1;
                    r_state <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (!i_stall) begin
                        r_ovld <= 1'b0;
                        if (r_ent == 4'd15) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ent   <= r_ent + 4'd1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers: operands, angles, MAC tags, output entry
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_op;
            r_x  <= i_x;
            r_y  <= i_y;
            r_z  <= i_z;
        end
        if (w_sc.done) begin
            r_cos <= w_sc.cos_v;
            r_sin <= w_sc.sin_v;
        end
        r_m_ctl.first <= (r_step[1:0] == 2'd0);
        r_m_ctl.last  <= (r_step[1:0] == 2'd3);
        r_m_ctl.ent   <= r_step[5:2];
        r_m_k         <= r_step[1:0];
        if (r_state == S_EMIT_LD) begin
            r_oidx  <= r_ent;
            r_oval  <= w_rdata;
            r_olast <= (r_ent == 4'd15);
        end
    end

    assign o_valid     = r_ovld;
    assign o_out_index = r_oidx;
    assign o_out_value = r_oval;
    assign o_last      = r_olast;

endmodule

`default_nettype wire
